// ----- hw/rtl/dpp_pkg.sv -----
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared constants for the depth point to pixel projection unit.
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIST_K1  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIST_K2  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DIST_K3  = 3'd6;

  // quotient bits of the normalizing divide, one per stage
  localparam int DIV_STAGES = 31;

  localparam logic signed [63:0] ONE_Q28   = 64'sd268435456;
  localparam logic signed [63:0] HALF_Q16  = 64'sd32768;
  localparam logic signed [63:0] F_MAX     = 64'sd8796093022207;
  localparam logic signed [63:0] F_MIN     = -64'sd8796093022208;
  localparam logic [15:0]        OFF_FRAME = 16'hFFFF;

endpackage

// ----- hw/rtl/dpp_div.sv -----
// ----------------------------------------------------------------------------
// dpp_div
// Pipelined restoring divider: (mag * 2^28) / den, one quotient bit per stage.
// Caller guarantees the quotient is below 2^31.
// ----------------------------------------------------------------------------
module dpp_div (
  input  logic        clk,
  input  logic [31:0] mag,
  input  logic [30:0] den,
  output logic [30:0] quot
);

  localparam int N = dpp_pkg::DIV_STAGES;

  logic [31:0] rem_q [0:N-1];
  logic [30:0] den_q [0:N-1];
  logic [30:0] quo_q [0:N-1];
  logic [2:0]  lo_q  [0:N-1];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [31:0] rin;
    logic [30:0] din;
    logic [30:0] qin;
    logic [2:0]  loin;
    logic        dbit;
    logic [31:0] sh;
    logic        ge;

    if (s == 0) begin : g_first
      assign rin  = {3'b000, mag[31:3]};
      assign din  = den;
      assign qin  = '0;
      assign loin = mag[2:0];
    end else begin : g_next
      assign rin  = rem_q[s-1];
      assign din  = den_q[s-1];
      assign qin  = quo_q[s-1];
      assign loin = lo_q[s-1];
    end

    // dividend bits below 28 are zero, the top three come from mag
    if (N - 1 - s >= 28) begin : g_bit
      assign dbit = loin[N-1-s-28];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    assign sh = {rin[30:0], dbit};
    assign ge = sh >= {1'b0, din};

    always_ff @(posedge clk) begin
      rem_q[s] <= ge ? sh - {1'b0, din} : sh;
      quo_q[s] <= {qin[29:0], ge};
      den_q[s] <= din;
      lo_q[s]  <= loin;
    end
  end

  assign quot = quo_q[N-1];

endmodule

// ----- hw/rtl/depth_point_to_pixel_projection_unit.sv -----
// ----------------------------------------------------------------------------
// depth_point_to_pixel_projection_unit
// Pinhole projection of a depth point to a pixel with k1/k2/k3 radial
// distortion, fully pipelined.
// ----------------------------------------------------------------------------
// throughput: one point per cycle, busy is never raised; results cannot be held off
// path from start to done: an input register, the 31-stage normalizing divider and
// 11 multiply/add stages
// rst clears the valid bits and the configuration registers; in-flight points are dropped
module depth_point_to_pixel_projection_unit #(
  parameter int FRAME_WIDTH  = 1280,
  parameter int FRAME_HEIGHT = 720
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] point_z,
  output logic        done,
  output logic [15:0] pixel_col,
  output logic [15:0] pixel_row,
  output logic        in_frame,
  output logic [19:0] pixel_index,
  input  logic        wr_en,
  input  logic [dpp_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [31:0] wr_data
);

  localparam int N = dpp_pkg::DIV_STAGES;

  // configuration
  logic [27:0] focal_x, focal_y, center_x, center_y;
  logic signed [31:0] dist_k1, dist_k2, dist_k3;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= '0;
      focal_y  <= '0;
      center_x <= '0;
      center_y <= '0;
      dist_k1  <= '0;
      dist_k2  <= '0;
      dist_k3  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        dpp_pkg::REG_FOCAL_X:  focal_x  <= wr_data[27:0];
        dpp_pkg::REG_FOCAL_Y:  focal_y  <= wr_data[27:0];
        dpp_pkg::REG_CENTER_X: center_x <= wr_data[27:0];
        dpp_pkg::REG_CENTER_Y: center_y <= wr_data[27:0];
        dpp_pkg::REG_DIST_K1:  dist_k1  <= wr_data;
        dpp_pkg::REG_DIST_K2:  dist_k2  <= wr_data;
        dpp_pkg::REG_DIST_K3:  dist_k3  <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage: magnitudes and the early reject
  logic        in_vld, in_bad, in_sx, in_sy;
  logic [31:0] in_mx, in_my;
  logic [30:0] in_z;
  logic [31:0] mx_c, my_c;
  logic [33:0] z8_c;
  logic        bad_c;

  always_comb begin
    mx_c  = point_x[31] ? 32'(-point_x) : point_x;
    my_c  = point_y[31] ? 32'(-point_y) : point_y;
    z8_c  = {point_z[30:0], 3'b000};
    // nonpositive depth, or |coord/z| at least 8.0
    bad_c = point_z[31] || (point_z == '0) ||
            ({2'b00, mx_c} >= z8_c) || ({2'b00, my_c} >= z8_c);
  end

  always_ff @(posedge clk) begin
    if (rst) in_vld <= 1'b0;
    else     in_vld <= start;
    in_bad <= bad_c;
    in_sx  <= point_x[31];
    in_sy  <= point_y[31];
    in_mx  <= mx_c;
    in_my  <= my_c;
    in_z   <= point_z[30:0];
  end

  logic [30:0] qx, qy;

  dpp_div u_div_x (.clk(clk), .mag(in_mx), .den(in_z), .quot(qx));
  dpp_div u_div_y (.clk(clk), .mag(in_my), .den(in_z), .quot(qy));

  // side band delay matching the divider
  logic [N-1:0] dl_vld;
  logic [N-1:0] dl_bad, dl_sx, dl_sy;

  always_ff @(posedge clk) begin
    if (rst) dl_vld <= '0;
    else     dl_vld <= {dl_vld[N-2:0], in_vld};
    dl_bad <= {dl_bad[N-2:0], in_bad};
    dl_sx  <= {dl_sx[N-2:0], in_sx};
    dl_sy  <= {dl_sy[N-2:0], in_sy};
  end

  // valid bits for stages a..j, reject bits for stages a..i
  logic [9:0] vld;
  logic [8:0] bad;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[8:0], dl_vld[N-1]};
    bad <= {bad[7:0], dl_bad[N-1]};
  end

  // a: signed normalized coordinates, Q4.28
  logic signed [31:0] u_a, v_a;
  always_ff @(posedge clk) begin
    u_a <= dl_sx[N-1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    v_a <= dl_sy[N-1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  end

  // b: squares
  logic signed [63:0] uu_b, vv_b;
  logic signed [31:0] u_b, v_b;
  always_ff @(posedge clk) begin
    uu_b <= u_a * u_a;
    vv_b <= v_a * v_a;
    u_b  <= u_a;
    v_b  <= v_a;
  end

  // c: r2
  logic [63:0] sum_c;
  logic [30:0] r2_c;
  logic signed [31:0] u_c, v_c;
  assign sum_c = 64'(uu_b) + 64'(vv_b);
  always_ff @(posedge clk) begin
    r2_c <= sum_c[62:32];
    u_c  <= u_b;
    v_c  <= v_b;
  end

  // d: r4 and the k1 term
  logic [61:0] r2sq;
  logic [37:0] r4_d;
  logic [30:0] r2_d;
  logic signed [63:0] t1_d;
  logic signed [31:0] u_d, v_d;
  assign r2sq = r2_c * r2_c;
  always_ff @(posedge clk) begin
    r4_d <= r2sq[61:24];
    r2_d <= r2_c;
    t1_d <= dist_k1 * $signed({1'b0, r2_c});
    u_d  <= u_c;
    v_d  <= v_c;
  end

  // e: r6 and the k2 term
  logic [60:0] r6p;
  logic [44:0] r6_e;
  logic signed [63:0] t1_e, t2_e;
  logic signed [31:0] u_e, v_e;
  assign r6p = r4_d[37:8] * r2_d;
  always_ff @(posedge clk) begin
    r6_e <= r6p[60:16];
    t1_e <= t1_d;
    t2_e <= dist_k2 * $signed({1'b0, r4_d[37:8]});
    u_e  <= u_d;
    v_e  <= v_d;
  end

  // f: k3 term
  logic signed [63:0] t1_f, t2_f, t3_f;
  logic signed [31:0] u_f, v_f;
  always_ff @(posedge clk) begin
    t1_f <= t1_e;
    t2_f <= t2_e;
    t3_f <= dist_k3 * $signed({1'b0, r6_e[44:16]});
    u_f  <= u_e;
    v_f  <= v_e;
  end

  // g: distortion factor with saturation, Q.28
  logic signed [63:0] fsum;
  logic signed [43:0] f_g;
  logic signed [31:0] u_g, v_g;
  assign fsum = dpp_pkg::ONE_Q28 + (t1_f >>> 24) + (t2_f >>> 16) + (t3_f >>> 8);
  always_ff @(posedge clk) begin
    if (fsum > dpp_pkg::F_MAX)      f_g <= dpp_pkg::F_MAX[43:0];
    else if (fsum < dpp_pkg::F_MIN) f_g <= dpp_pkg::F_MIN[43:0];
    else                            f_g <= fsum[43:0];
    u_g <= u_f;
    v_g <= v_f;
  end

  // h: distorted coordinates
  logic signed [31:0] fs;
  logic signed [63:0] dx_h, dy_h;
  assign fs = f_g[43:12];
  always_ff @(posedge clk) begin
    dx_h <= u_g * fs;
    dy_h <= v_g * fs;
  end

  // i: focal scaling, the two floor shifts fold into one
  logic signed [33:0] ddx, ddy;
  logic signed [63:0] fx_i, fy_i;
  assign ddx = dx_h[63:30];
  assign ddy = dy_h[63:30];
  always_ff @(posedge clk) begin
    fx_i <= $signed({1'b0, focal_x}) * ddx;
    fy_i <= $signed({1'b0, focal_y}) * ddy;
  end

  // j: principal point, rounding and frame check
  logic signed [63:0] px, py;
  logic ok_x, ok_y;
  logic [15:0] col_j, row_j;
  logic ok_j;
  assign px = (fx_i >>> 14) + $signed({36'd0, center_x}) + dpp_pkg::HALF_Q16;
  assign py = (fy_i >>> 14) + $signed({36'd0, center_y}) + dpp_pkg::HALF_Q16;
  // p in (-1, 0) truncates to 0, the only negative p that stays in frame
  assign ok_x = (!px[63] && (px[63:16] < 48'(FRAME_WIDTH))) ||
                (px[63:16] == '1 && px[15:0] != '0);
  assign ok_y = (!py[63] && (py[63:16] < 48'(FRAME_HEIGHT))) ||
                (py[63:16] == '1 && py[15:0] != '0);
  always_ff @(posedge clk) begin
    col_j <= px[63] ? 16'd0 : px[31:16];
    row_j <= py[63] ? 16'd0 : py[31:16];
    ok_j  <= ok_x && ok_y && !bad[8];
  end

  // k: linear index and result registers
  logic [31:0] idx;
  assign idx = 32'(row_j) * 32'(FRAME_WIDTH) + 32'(col_j);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld[9];
    pixel_col   <= ok_j ? col_j : dpp_pkg::OFF_FRAME;
    pixel_row   <= ok_j ? row_j : dpp_pkg::OFF_FRAME;
    in_frame    <= ok_j;
    pixel_index <= ok_j ? idx[19:0] : '0;
  end

endmodule
